// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Default sizes of the allocation map and the longest chain.
  localparam int NUM_BLOCKS_DEF = 256;
  localparam int MAX_CHAIN_DEF  = 64;

  // Field widths of the beats and of the register.
  localparam int OP_W    = 2;
  localparam int CNT_W   = 9;
  localparam int BLK_W   = 8;
  localparam int STAT_W  = 2;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_ALLOC_CONTIG = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_CHAIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE         = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR        = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [CNT_W-1:0] count;
    logic [BLK_W-1:0] block_index;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  block;
    logic              last;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/block_bitmap_allocator.sv =====
// First-fit block allocator over a one-bit used/free map held in a single-port-write,
// single-port-read memory that is walked by a small sequencer, one block per cycle
// during a scan. A contiguous request scans blocks 0 .. n-1 (n is cfg_wdata as last
// written, capped at NUM_BLOCKS) until a long enough free run is found, then marks
// the run one block per cycle. A chained request scans once to prove there are enough
// free blocks, then walks again from block 0 up to the last free block found, reading
// each block and claiming and sending one beat for each free one. A free writes the
// map as the request is taken. Clear all sweeps the whole memory; after reset the
// same sweep runs before the first request is taken; configuration writes are taken
// at any time. One request is worked on at a time; a finished result sits in the
// output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int MAX_CHAIN  = MAX_CHAIN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Configuration port.
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  // Request channel.
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_beat_t         in_beat,
  // Result channel.
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_beat_t             out_beat
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int NB_W  = $clog2(NUM_BLOCKS + 1);
  localparam int ACT_W = (NB_W > CNT_W) ? NB_W : CNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLR    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MARK   = 3'd3;
  localparam logic [2:0] S_C2_RD  = 3'd4;
  localparam logic [2:0] S_C2_EV  = 3'd5;
  localparam logic [2:0] S_C2_OUT = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  // Allocation map memory.
  logic map_mem [NUM_BLOCKS];
  logic             rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_data;

  // Control and working registers.
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cfg_r;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ACT_W-1:0]  scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [IDX_W-1:0]  end_r, end_nxt;
  logic [IDX_W-1:0]  mark_r, mark_nxt;
  logic              reply_r, reply_nxt;
  logic [STAT_W-1:0] resp_stat_r, resp_stat_nxt;
  logic [BLK_W-1:0]  resp_blk_r, resp_blk_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;

  logic [ACT_W-1:0]  n_act;
  logic              out_free;
  logic              in_acc;
  logic              scan_hit;

  // Blocks in use, capped at the size of the map.
  assign n_act = (ACT_W'(cfg_r) > ACT_W'(NUM_BLOCKS)) ? ACT_W'(NUM_BLOCKS) : ACT_W'(cfg_r);

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    mark_nxt      = mark_r;
    reply_nxt     = reply_r;
    resp_stat_nxt = resp_stat_r;
    resp_blk_nxt  = resp_blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    rd_addr       = mark_r;
    wr_en         = 1'b0;
    wr_addr       = mark_r;
    wr_data       = 1'b0;
    scan_hit      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_beat.opcode;
          count_nxt = in_beat.count;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          run_nxt   = '0;
          case (in_beat.opcode)
            OP_ALLOC_CONTIG, OP_ALLOC_CHAIN: begin
              if (in_beat.count == '0 ||
                  (in_beat.opcode == OP_ALLOC_CHAIN &&
                   in_beat.count > CNT_W'(MAX_CHAIN))) begin
                out_valid_nxt = 1'b1;
                out_beat_nxt  = '{status: STAT_BAD, block: '0, last: 1'b1};
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_FREE: begin
              out_valid_nxt = 1'b1;
              if (ACT_W'(in_beat.block_index) >= n_act) begin
                out_beat_nxt = '{status: STAT_BAD, block: in_beat.block_index, last: 1'b1};
              end else begin
                wr_en        = 1'b1;
                wr_addr      = IDX_W'(in_beat.block_index);
                wr_data      = 1'b0;
                out_beat_nxt = '{status: STAT_OK, block: in_beat.block_index, last: 1'b1};
              end
            end
            default: begin
              mark_nxt  = '0;
              reply_nxt = 1'b1;
              state_nxt = S_CLR;
            end
          endcase
        end
      end

      // Sweep the whole map back to free.
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = mark_r;
        wr_data = 1'b0;
        if (mark_r == IDX_W'(NUM_BLOCKS - 1)) begin
          resp_stat_nxt = STAT_OK;
          resp_blk_nxt  = '0;
          state_nxt     = reply_r ? S_RESP : S_IDLE;
        end else begin
          mark_nxt = mark_r + 1'b1;
        end
      end

      // Pipelined walk: one read issued per cycle, the previous one evaluated.
      S_SCAN: begin
        rd_addr = scan_r[IDX_W-1:0];
        if (pend_r && !rd_data_r) begin
          if (op_r == OP_ALLOC_CONTIG) begin
            if (run_r == '0) begin
              start_nxt = pidx_r;
            end
            run_nxt = run_r + 1'b1;
            if (({1'b0, run_r} + 1'b1) >= {1'b0, count_r}) begin
              scan_hit  = 1'b1;
              end_nxt   = pidx_r;
              mark_nxt  = (run_r == '0) ? pidx_r : start_r;
              state_nxt = S_MARK;
            end
          end else begin
            run_nxt = run_r + 1'b1;
            if ((run_r + 1'b1) == count_r) begin
              scan_hit  = 1'b1;
              end_nxt   = pidx_r;
              mark_nxt  = '0;
              state_nxt = S_C2_RD;
            end
          end
        end else if (pend_r && op_r == OP_ALLOC_CONTIG) begin
          run_nxt = '0;
        end

        if (scan_hit) begin
          pend_nxt = 1'b0;
        end else if (scan_r < n_act) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[IDX_W-1:0];
          scan_nxt = scan_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            resp_stat_nxt = STAT_NO_SPACE;
            resp_blk_nxt  = '0;
            state_nxt     = S_RESP;
          end
        end
      end

      // Mark the found run as used.
      S_MARK: begin
        wr_en   = 1'b1;
        wr_addr = mark_r;
        wr_data = 1'b1;
        if (mark_r == end_r) begin
          resp_stat_nxt = STAT_OK;
          resp_blk_nxt  = BLK_W'(start_r);
          state_nxt     = S_RESP;
        end else begin
          mark_nxt = mark_r + 1'b1;
        end
      end

      // Second chained pass: claim free blocks up to the last one found.
      S_C2_RD: begin
        rd_addr   = mark_r;
        state_nxt = S_C2_EV;
      end

      S_C2_EV: begin
        if (!rd_data_r) begin
          wr_en     = 1'b1;
          wr_addr   = mark_r;
          wr_data   = 1'b1;
          state_nxt = S_C2_OUT;
        end else begin
          mark_nxt  = mark_r + 1'b1;
          state_nxt = S_C2_RD;
        end
      end

      S_C2_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{status: STAT_OK, block: BLK_W'(mark_r), last: (mark_r == end_r)};
          if (mark_r == end_r) begin
            state_nxt = S_IDLE;
          end else begin
            mark_nxt  = mark_r + 1'b1;
            state_nxt = S_C2_RD;
          end
        end
      end

      // Single final beat of a request.
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{status: resp_stat_r, block: resp_blk_r, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Map memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= map_mem[rd_addr];
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    count_r     <= count_nxt;
    scan_r      <= scan_nxt;
    pidx_r      <= pidx_nxt;
    run_r       <= run_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    resp_stat_r <= resp_stat_nxt;
    resp_blk_r  <= resp_blk_nxt;
    out_beat_r  <= out_beat_nxt;
  end

  // Control registers; reset starts the clearing sweep without a reply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      mark_r      <= '0;
      reply_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= CNT_W'(256);
    end else begin
      state_r     <= state_nxt;
      mark_r      <= mark_nxt;
      reply_r     <= reply_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_beat
);

  // A stalled result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.status == STAT_OK || out_beat.status == STAT_NO_SPACE ||
                   out_beat.status == STAT_BAD))
    else $error("undefined status code");

  // A failed request answers exactly one beat, so it is always the last one.
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status != STAT_OK |-> out_beat.last)
    else $error("failure beat without last");

  // A no-space answer carries block zero.
  a_nospace_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == STAT_NO_SPACE |-> out_beat.block == '0)
    else $error("no-space beat with nonzero block");

  // Requests are not taken while a result is stuck in the output register.
  a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall || !in_valid)
    else $error("request taken while result blocked");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);

`default_nettype wire

// ===== tb/block_bitmap_allocator_tb.sv =====
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;
  import bba_pkg::*;

  localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;
  localparam int MAX_CHAIN  = MAX_CHAIN_DEF;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_WAIT = 1000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_beat_t         in_beat   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_beat;

  // Allocator model: its own copy of the used/free map and the size register.
  logic [NUM_BLOCKS-1:0] used_map = '0;
  logic [CNT_W-1:0]      map_size = CNT_W'(NUM_BLOCKS);

  in_beat_t  request_q[$];
  out_beat_t result_q[$];
  int        items_pushed = 0;
  int        items_taken  = 0;
  int        mismatch_cnt = 0;
  bit        beat_taken   = 1'b0;
  bit        idle_on      = 1'b1;
  int        send_gap     = 0;
  int        recv_gap     = 0;
  int        hold_asked   = 0;
  int        hold_served  = 0;
  int        hold_left    = 0;

  block_bitmap_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void push_result(input logic [STAT_W-1:0] st, input int blk,
                                      input logic lst);
    out_beat_t r;
    r.status = st;
    r.block  = BLK_W'(blk);
    r.last   = lst;
    result_q.push_back(r);
  endfunction

  // Work out the result beats of one request and update the map.
  function automatic void apply_request(input in_beat_t req);
    int n;
    int run;
    int start;
    int found;
    int picks[$];
    n = (map_size > NUM_BLOCKS) ? NUM_BLOCKS : int'(map_size);
    run = 0;
    start = 0;
    found = 0;
    case (req.opcode)
      OP_ALLOC_CONTIG: begin
        if (req.count == 0) begin
          push_result(STAT_BAD, 0, 1'b1);
        end else begin
          // First fit: lowest free run that is long enough.
          for (int i = 0; i < n && found == 0; i++) begin
            if (used_map[i]) begin
              run = 0;
            end else begin
              if (run == 0) start = i;
              run++;
              if (run >= req.count) begin
                for (int j = start; j <= i; j++) used_map[j] = 1'b1;
                push_result(STAT_OK, start, 1'b1);
                found = 1;
              end
            end
          end
          if (found == 0) push_result(STAT_NO_SPACE, 0, 1'b1);
        end
      end
      OP_ALLOC_CHAIN: begin
        if (req.count == 0 || req.count > MAX_CHAIN) begin
          push_result(STAT_BAD, 0, 1'b1);
        end else begin
          for (int i = 0; i < n && found < req.count; i++) begin
            if (!used_map[i]) begin
              picks.push_back(i);
              found++;
            end
          end
          if (found < req.count) begin
            push_result(STAT_NO_SPACE, 0, 1'b1);
          end else begin
            foreach (picks[k]) begin
              used_map[picks[k]] = 1'b1;
              push_result(STAT_OK, picks[k], k == picks.size() - 1);
            end
          end
        end
      end
      OP_FREE: begin
        if (req.block_index >= n) begin
          push_result(STAT_BAD, req.block_index, 1'b1);
        end else begin
          used_map[req.block_index] = 1'b0;
          push_result(STAT_OK, req.block_index, 1'b1);
        end
      end
      default: begin
        used_map = '0;
        push_result(STAT_OK, 0, 1'b1);
      end
    endcase
  endfunction

  // Monitor: register writes, accepted requests and accepted results.
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst_n) begin
      used_map = '0;
      map_size = CNT_W'(NUM_BLOCKS);
    end else begin
      if (cfg_we) map_size = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat status=%0d block=%0d last=%0d",
                                    out_beat.status, out_beat.block, out_beat.last));
        end else begin
          exp_beat = result_q.pop_front();
          if (out_beat.status !== exp_beat.status || out_beat.block !== exp_beat.block ||
              out_beat.last !== exp_beat.last) begin
            report_mismatch($sformatf("got status=%0d block=%0d last=%0d, want %0d %0d %0d",
                                      out_beat.status, out_beat.block, out_beat.last,
                                      exp_beat.status, exp_beat.block, exp_beat.last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        beat_taken = 1'b1;
        items_taken++;
        apply_request(in_beat);
      end
    end
  end

  // Request driver: holds a beat until it is taken, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !beat_taken)) begin
      beat_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_beat  <= request_q.pop_front();
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input int cnt, input int idx);
    in_beat_t req;
    req.opcode      = op;
    req.count       = CNT_W'(cnt);
    req.block_index = BLK_W'(idx);
    request_q.push_back(req);
    items_pushed++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_pushed || result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_map_size(input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int cfg_val;
    int n;
    int sel;
    int pick;
    int cnt;
    int idx;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Full map: bad counts, a chain of the longest length, runs and frees.
    write_map_size(NUM_BLOCKS);
    send(OP_ALLOC_CONTIG, 0, 0);
    send(OP_ALLOC_CHAIN, 0, 255);
    send(OP_ALLOC_CHAIN, MAX_CHAIN + 1, 0);
    send(OP_ALLOC_CHAIN, MAX_CHAIN, 0);
    send(OP_ALLOC_CONTIG, 256, 0);
    send(OP_ALLOC_CONTIG, 192, 0);
    send(OP_FREE, 0, 255);
    send(OP_FREE, 0, 100);
    send(OP_FREE, 511, 100);
    send(OP_ALLOC_CHAIN, 2, 0);
    send(OP_ALLOC_CHAIN, 1, 0);
    send(OP_ALLOC_CONTIG, 1, 0);
    send(OP_CLEAR, 511, 255);
    send(OP_ALLOC_CONTIG, 256, 0);
    send(OP_CLEAR, 0, 0);
    send(OP_ALLOC_CONTIG, 511, 0);
    send(OP_ALLOC_CHAIN, 511, 0);
    wait_drained();

    // One block in use; the map keeps what was left above.
    write_map_size(1);
    send(OP_ALLOC_CONTIG, 1, 0);
    send(OP_ALLOC_CONTIG, 1, 0);
    send(OP_FREE, 0, 1);
    send(OP_FREE, 0, 0);
    send(OP_ALLOC_CHAIN, 1, 0);
    send(OP_FREE, 0, 255);
    wait_drained();

    // No blocks at all.
    write_map_size(0);
    send(OP_ALLOC_CONTIG, 1, 0);
    send(OP_ALLOC_CHAIN, 1, 0);
    send(OP_FREE, 0, 0);
    send(OP_CLEAR, 0, 0);
    wait_drained();

    // Oversized register acts as the full map.
    write_map_size(511);
    send(OP_ALLOC_CHAIN, 3, 0);
    send(OP_FREE, 0, 255);
    wait_drained();

    // Random phases, each behind a drain and a new register value.
    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      case (phase)
        0:       cfg_val = NUM_BLOCKS;
        3:       cfg_val = 1;
        5:       cfg_val = 2;
        7:       cfg_val = 511;
        default: cfg_val = $urandom_range(1, NUM_BLOCKS);
      endcase
      write_map_size(cfg_val);
      n = (cfg_val > NUM_BLOCKS) ? NUM_BLOCKS : cfg_val;
      idle_on = (phase % 3 != 2) && (phase < 8);
      // Hold results back for a long stretch while requests keep coming.
      if (phase == 1) hold_asked++;
      for (int k = 0; k < 50; k++) begin
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 19);
        cnt  = $urandom_range(0, 511);
        idx  = $urandom_range(0, 255);
        if (sel < 38) begin
          if (pick == 0) cnt = 0;
          else if (pick < 3) cnt = $urandom_range(1, n);
          else if (pick > 3) cnt = $urandom_range(1, (n < 12) ? n : 12);
          send(OP_ALLOC_CONTIG, cnt, idx);
        end else if (sel < 74) begin
          if (pick == 0) cnt = 0;
          else if (pick == 1) cnt = $urandom_range(MAX_CHAIN + 1, 511);
          else if (pick == 2) cnt = $urandom_range(1, MAX_CHAIN);
          else cnt = $urandom_range(1, 6);
          send(OP_ALLOC_CHAIN, cnt, idx);
        end else if (sel < 96) begin
          if (pick > 3) idx = $urandom_range(0, n - 1);
          send(OP_FREE, cnt, idx);
        end else begin
          send(OP_CLEAR, cnt, idx);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (result_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", result_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #(30_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
